>>> src/bitmap_first_fit_allocator_macros.svh
// assertion helpers shared by the checker
`ifndef BITMAP_FIRST_FIT_ALLOCATOR_MACROS_SVH
`define BITMAP_FIRST_FIT_ALLOCATOR_MACROS_SVH

// same-cycle implication, masked while in reset
`define BFFA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bffa check failed");

// next-cycle implication, masked while in reset
`define BFFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bffa check failed");

`endif

>>> src/bffa_pkg.sv
package bffa_pkg;

    localparam int BLOCK_COUNT  = 64;
    localparam int BLOCK_BYTES  = 64;
    localparam int HEADER_BYTES = 16;

    localparam int IDX_W   = $clog2(BLOCK_COUNT);
    localparam int LEN_W   = $clog2(BLOCK_COUNT + 1);
    localparam int BB_SH   = $clog2(BLOCK_BYTES);
    localparam int POOL_BYTES = BLOCK_COUNT * BLOCK_BYTES;

    // field widths of the request and result
    localparam int ACTION_W  = 1;
    localparam int BYTES_W   = 16;
    localparam int ADDR_W    = 12;
    localparam int STATUS_W  = 2;
    localparam int OFFSET_W  = 12;
    localparam int CHANGED_W = 7;
    localparam int TOTAL_W   = BYTES_W + 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ALLOC = 1'b0,
        ACT_FREE  = 1'b1
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NO_SPACE  = 2'd1,
        ST_OUTSIDE   = 2'd2,
        ST_NOT_START = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_CHECK,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic    capture;
        logic    scan_init;
        logic    scan_step;
        logic    commit_alloc;
        logic    rd_en;
        logic    commit_free;
        logic    decide;
        status_t status;
        logic    load_result;
    } dp_cmd_t;

    typedef struct packed {
        logic is_free;
        logic too_big;
        logic outside;
        logic misaligned;
        logic found;
        logic scan_last;
        logic run_ok;
        logic out_busy;
    } dp_sts_t;

endpackage

>>> src/bffa_intf.sv
interface bffa_req_if import bffa_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [BYTES_W-1:0]  request_bytes;
    logic [ADDR_W-1:0]   free_address;

    modport source (output valid, output action, output request_bytes, output free_address,
                    input ready);
    modport sink   (input valid, input action, input request_bytes, input free_address,
                    output ready);
endinterface

interface bffa_rsp_if import bffa_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [OFFSET_W-1:0]  payload_offset;
    logic [CHANGED_W-1:0] blocks_changed;

    modport source (output valid, output status, output payload_offset, output blocks_changed,
                    input ready);
    modport sink   (input valid, input status, input payload_offset, input blocks_changed,
                    output ready);
endinterface

>>> src/bffa_ctrl.sv
module bffa_ctrl import bffa_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status = ST_OK;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (!sts.is_free)
                begin
                    if (sts.too_big)
                    begin
                        cmd.decide = 1'b1;
                        cmd.status = ST_NO_SPACE;
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        cmd.scan_init = 1'b1;
                        state_next    = S_SCAN;
                    end
                end
                else if (sts.outside)
                begin
                    cmd.decide = 1'b1;
                    cmd.status = ST_OUTSIDE;
                    state_next = S_RESULT;
                end
                else if (sts.misaligned)
                begin
                    cmd.decide = 1'b1;
                    cmd.status = ST_NOT_START;
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.found)
                begin
                    cmd.commit_alloc = 1'b1;
                    cmd.decide       = 1'b1;
                    cmd.status       = ST_OK;
                    state_next       = S_RESULT;
                end
                else if (sts.scan_last)
                begin
                    cmd.decide = 1'b1;
                    cmd.status = ST_NO_SPACE;
                    state_next = S_RESULT;
                end
            end
            S_CHECK:
            begin
                cmd.decide = 1'b1;
                if (sts.run_ok)
                begin
                    cmd.commit_free = 1'b1;
                    cmd.status      = ST_OK;
                end
                else
                begin
                    cmd.status = ST_NOT_START;
                end
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (!sts.out_busy)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> src/bffa_dp.sv
module bffa_dp import bffa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [ACTION_W-1:0]  action,
    input  logic [BYTES_W-1:0]   request_bytes,
    input  logic [ADDR_W-1:0]    free_address,
    input  dp_cmd_t              cmd,
    output dp_sts_t              sts,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [STATUS_W-1:0]  status,
    output logic [OFFSET_W-1:0]  payload_offset,
    output logic [CHANGED_W-1:0] blocks_changed
);

    // captured request
    logic                 is_free_reg;
    logic                 too_big_reg;
    logic [LEN_W-1:0]     want_reg;
    logic [ADDR_W-1:0]    addr_reg;

    // block state
    logic [BLOCK_COUNT-1:0] used_reg;
    logic [BLOCK_COUNT-1:0] rl_valid_reg;
    logic [LEN_W-1:0]       rl_mem [BLOCK_COUNT];
    logic [LEN_W-1:0]       rl_q_reg;

    // scan
    logic [IDX_W-1:0] b_reg;
    logic [LEN_W-1:0] run_reg;
    logic [LEN_W-1:0] run_next;
    logic [IDX_W:0]   start_w;
    logic [IDX_W-1:0] start;

    // result
    status_t              pend_status_reg;
    logic [OFFSET_W-1:0]  pend_offset_reg;
    logic [CHANGED_W-1:0] pend_changed_reg;
    logic                 out_valid_reg;
    status_t              out_status_reg;
    logic [OFFSET_W-1:0]  out_offset_reg;
    logic [CHANGED_W-1:0] out_changed_reg;

    logic [TOTAL_W-1:0]   total;
    logic [TOTAL_W-1:0]   want_w;
    logic [ADDR_W-1:0]    rel;
    logic [ADDR_W-1:0]    idx_w;
    logic [IDX_W-1:0]     idx;
    logic [IDX_W-1:0]     mask_lo;
    logic [LEN_W-1:0]     mask_len;
    logic [IDX_W+1:0]     mask_hi;
    logic [BLOCK_COUNT-1:0] range_mask;
    logic [OFFSET_W-1:0]  alloc_offset;

    // blocks needed: header added, rounded up, at least one
    always_comb
    begin
        total  = TOTAL_W'(request_bytes) + TOTAL_W'(HEADER_BYTES);
        want_w = (total + TOTAL_W'(BLOCK_BYTES - 1)) >> BB_SH;
        if (want_w == '0)
        begin
            want_w = TOTAL_W'(1);
        end
    end

    assign rel   = addr_reg - ADDR_W'(HEADER_BYTES);
    assign idx_w = rel >> BB_SH;
    assign idx   = idx_w[IDX_W-1:0];

    assign run_next = used_reg[b_reg] ? '0 : run_reg + LEN_W'(1);
    assign start_w  = (IDX_W+1)'(b_reg) + (IDX_W+1)'(1) - (IDX_W+1)'(want_reg);
    assign start    = start_w[IDX_W-1:0];

    // run covered by this commit, alloc or free
    assign mask_lo  = cmd.commit_alloc ? start : idx;
    assign mask_len = cmd.commit_alloc ? want_reg : rl_q_reg;
    assign mask_hi  = (IDX_W+2)'(mask_lo) + (IDX_W+2)'(mask_len);

    always_comb
    begin
        for (int i = 0; i < BLOCK_COUNT; i++)
        begin
            range_mask[i] = ((IDX_W+2)'(i) >= (IDX_W+2)'(mask_lo)) &&
                            ((IDX_W+2)'(i) < mask_hi);
        end
    end

    assign alloc_offset = OFFSET_W'(32'(start) * BLOCK_BYTES + HEADER_BYTES);

    always_comb
    begin
        sts            = '0;
        sts.is_free    = is_free_reg;
        sts.too_big    = too_big_reg;
        sts.outside    = (addr_reg < ADDR_W'(HEADER_BYTES)) ||
                         (32'(addr_reg) >= POOL_BYTES);
        sts.misaligned = (rel[BB_SH-1:0] != '0) || (32'(idx_w) >= BLOCK_COUNT);
        sts.found      = (run_next == want_reg);
        sts.scan_last  = (b_reg == IDX_W'(BLOCK_COUNT - 1));
        sts.run_ok     = used_reg[idx] && rl_valid_reg[idx] && (rl_q_reg != '0);
        sts.out_busy   = out_valid_reg && !out_ready;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            is_free_reg <= (action == ACT_FREE);
            too_big_reg <= (32'(want_w) > BLOCK_COUNT);
            want_reg    <= LEN_W'(want_w);
            addr_reg    <= free_address;
        end
        if (cmd.scan_init)
        begin
            b_reg   <= '0;
            run_reg <= '0;
        end
        else if (cmd.scan_step)
        begin
            b_reg   <= b_reg + IDX_W'(1);
            run_reg <= run_next;
        end
    end

    // run length store
    always_ff @(posedge clk)
    begin
        if (cmd.commit_alloc)
        begin
            rl_mem[start] <= want_reg;
        end
        if (cmd.rd_en)
        begin
            rl_q_reg <= rl_mem[idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg     <= '0;
            rl_valid_reg <= '0;
        end
        else if (cmd.commit_alloc)
        begin
            used_reg            <= used_reg | range_mask;
            rl_valid_reg[start] <= 1'b1;
        end
        else if (cmd.commit_free)
        begin
            used_reg          <= used_reg & ~range_mask;
            rl_valid_reg[idx] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.decide)
        begin
            pend_status_reg  <= cmd.status;
            pend_offset_reg  <= '0;
            pend_changed_reg <= '0;
            if (cmd.status == ST_OK)
            begin
                if (is_free_reg)
                begin
                    pend_changed_reg <= CHANGED_W'(rl_q_reg);
                end
                else
                begin
                    pend_offset_reg  <= alloc_offset;
                    pend_changed_reg <= CHANGED_W'(want_reg);
                end
            end
        end
        if (cmd.load_result)
        begin
            out_status_reg  <= pend_status_reg;
            out_offset_reg  <= pend_offset_reg;
            out_changed_reg <= pend_changed_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign payload_offset = out_offset_reg;
    assign blocks_changed = out_changed_reg;

endmodule

>>> src/bitmap_first_fit_allocator.sv
// Bitmap first-fit allocator over a pool of BLOCK_COUNT blocks of BLOCK_BYTES bytes. One request
// is handled at a time. An allocate scans the used map one block per cycle from block 0 and stops
// at the first free run long enough; a run too long for the pool is refused without a scan. A
// free does a registered read of the run-length memory before its check, and is refused without
// the read when the offset lies outside the pool or off a block boundary. The next request is
// taken in the cycle after the result is loaded. Marking or releasing a run is done in a single
// write of the used map. A finished result sits in an output register, and the next request is
// taken while it waits; a result that is ready while the previous one still waits holds the block
// until the output is taken. No clearing pass is needed after reset.
module bitmap_first_fit_allocator import bffa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    bffa_req_if.sink   req,
    bffa_rsp_if.source rsp
);

    dp_cmd_t cmd;
    dp_sts_t sts;
    logic    ready;

    bffa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bffa_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .action         (req.action),
        .request_bytes  (req.request_bytes),
        .free_address   (req.free_address),
        .cmd            (cmd),
        .sts            (sts),
        .out_valid      (rsp.valid),
        .out_ready      (rsp.ready),
        .status         (rsp.status),
        .payload_offset (rsp.payload_offset),
        .blocks_changed (rsp.blocks_changed)
    );

    assign req.ready = ready;

endmodule

>>> src/bffa_chk.sv
`include "bitmap_first_fit_allocator_macros.svh"

module bffa_chk import bffa_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [STATUS_W-1:0]  status,
    input logic [OFFSET_W-1:0]  payload_offset,
    input logic [CHANGED_W-1:0] blocks_changed
);

    // a refused request changes nothing and reports zeros
    `BFFA_ASSERT_NOW(a_reject_zero, clk, rst_n, out_valid && (status != ST_OK), (payload_offset == '0) && (blocks_changed == '0))

    // a granted or released run is never empty nor longer than the pool
    `BFFA_ASSERT_NOW(a_ok_len, clk, rst_n, out_valid && (status == ST_OK), (blocks_changed != '0) && (32'(blocks_changed) <= BLOCK_COUNT))

    // one request in flight at a time
    `BFFA_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready)

    // a waiting result holds
    `BFFA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(payload_offset) && $stable(blocks_changed))

endmodule

bind bitmap_first_fit_allocator bffa_chk u_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (req.valid),
    .in_ready       (req.ready),
    .out_valid      (rsp.valid),
    .out_ready      (rsp.ready),
    .status         (rsp.status),
    .payload_offset (rsp.payload_offset),
    .blocks_changed (rsp.blocks_changed)
);
